/* rtl/core/fmts_pkg.sv */
// Shared types, codes and constants for the FM tuner step and seek controller.
// No dependencies; imported by every module of the block except fmts_fifo.
`timescale 1ns / 1ps

package fmts_pkg;

    // Widths of the item fields
    localparam int FREQ_W  = 11;
    localparam int RSSI_W  = 8;
    localparam int LIMIT_W = 10;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 3;
    localparam int SEG_W   = 8;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STEP_UP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEP_DOWN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEEK_UP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEEK_DOWN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MEASURE   = 3'd5;

    // Seek outcome codes
    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_FOUND   = 2'd1;
    localparam logic [1:0] OUTCOME_KEY     = 2'd2;
    localparam logic [1:0] OUTCOME_GAVE_UP = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_IDX_THRESHOLD  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_STEP_LIMIT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_BAND_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_IDX_BAND_HIGH  = 3'd3;

    // Reset values
    localparam logic [RSSI_W-1:0]  THRESHOLD_RST  = 8'd23;
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 10'd321;
    localparam logic [FREQ_W-1:0]  BAND_LOW_RST   = 11'd760;
    localparam logic [FREQ_W-1:0]  BAND_HIGH_RST  = 11'd1080;
    localparam logic [FREQ_W-1:0]  FREQ_RST       = 11'd778;

    // Display constants
    localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

    // Command classes handed from front to back
    typedef enum logic [2:0] {
        CMD_SET,
        CMD_STEP_UP,
        CMD_STEP_DOWN,
        CMD_SEEK_UP,
        CMD_SEEK_DOWN,
        CMD_MEASURE,
        CMD_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [FREQ_W-1:0]   new_freq;
        logic [RSSI_W-1:0]   rssi_avg;
        logic                key;
    } cmd_t;

    typedef struct packed {
        logic [RSSI_W-1:0]  rssi_threshold;
        logic [LIMIT_W-1:0] seek_step_limit;
        logic [FREQ_W-1:0]  band_low;
        logic [FREQ_W-1:0]  band_high;
    } cfg_t;

    // Result of the executor, before the display conversion
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              tune;
        logic              running;
        logic [1:0]        outcome;
    } res_t;

    // Full result transaction
    typedef struct packed {
        res_t             res;
        logic [SEG_W-1:0] seg_thousands;
        logic [SEG_W-1:0] seg_hundreds;
        logic [SEG_W-1:0] seg_tens;
        logic [SEG_W-1:0] seg_units;
    } disp_t;

    // Seven-segment font, active low
    function automatic logic [SEG_W-1:0] seg_glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] g;
        case (digit)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/fmts_fifo.sv */
// Small register-based first-in first-out queue of generic width and depth.
// No dependencies; used for the command queue and the result queue.
`timescale 1ns / 1ps

module fmts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/fmts_front.sv */
// Front end: accepts input transactions, classifies the mode and averages the
// two readings, then queues the command. Depends on fmts_pkg and fmts_fifo.
`timescale 1ns / 1ps

module fmts_front
    import fmts_pkg::*;
#(
    parameter int CMD_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [MODE_W-1:0] mode,
    input  logic [FREQ_W-1:0] new_frequency,
    input  logic [RSSI_W-1:0] rssi_first,
    input  logic [RSSI_W-1:0] rssi_second,
    input  logic              key_down,
    output cmd_t              cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);

    cmd_t            cmd_in;
    cmd_kind_t       kind;
    logic [RSSI_W:0] rssi_sum;
    logic            q_empty;

    // Mode decoder
    always_comb
    begin
        unique case (mode)
            MODE_SET:       kind = CMD_SET;
            MODE_STEP_UP:   kind = CMD_STEP_UP;
            MODE_STEP_DOWN: kind = CMD_STEP_DOWN;
            MODE_SEEK_UP:   kind = CMD_SEEK_UP;
            MODE_SEEK_DOWN: kind = CMD_SEEK_DOWN;
            MODE_MEASURE:   kind = CMD_MEASURE;
            default:        kind = CMD_NONE;
        endcase
    end

    // Average of the two readings, rounded down
    assign rssi_sum = {1'b0, rssi_first} + {1'b0, rssi_second};

    assign cmd_in.kind     = kind;
    assign cmd_in.new_freq = new_frequency;
    assign cmd_in.rssi_avg = rssi_sum[RSSI_W:1];
    assign cmd_in.key      = key_down;

    fmts_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .full    (full),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;

endmodule

/* rtl/core/fmts_back.sv */
// Back end: executes queued commands on the tuner and seek state, one per
// cycle while the display path has space, and registers the result. Depends on fmts_pkg.
`timescale 1ns / 1ps

module fmts_back
    import fmts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  logic space,
    output res_t res,
    output logic res_valid
);

    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [FREQ_W-1:0]  origin_reg, origin_next;
    logic               upward_reg, upward_next;
    logic               busy_reg, busy_next;
    logic [LIMIT_W-1:0] failed_reg, failed_next;
    res_t               res_reg, res_next;
    logic               res_valid_reg;

    logic [FREQ_W:0]    freq_inc;
    logic [FREQ_W-1:0]  up_freq;
    logic [FREQ_W-1:0]  down_freq;
    logic [LIMIT_W-1:0] failed_inc;
    logic               issue;

    assign issue   = cmd_valid && space;
    assign cmd_pop = issue;

    // Wrapping neighbours of the current frequency
    assign freq_inc   = {1'b0, freq_reg} + 1'b1;
    assign up_freq    = (freq_inc > {1'b0, cfg.band_high}) ? cfg.band_low
                                                           : freq_inc[FREQ_W-1:0];
    assign down_freq  = (freq_reg <= cfg.band_low) ? cfg.band_high : freq_reg - 1'b1;
    assign failed_inc = failed_reg + 1'b1;

    // Command execution
    always_comb
    begin
        freq_next        = freq_reg;
        origin_next      = origin_reg;
        upward_next      = upward_reg;
        busy_next        = busy_reg;
        failed_next      = failed_reg;
        res_next.tune    = 1'b0;
        res_next.outcome = OUTCOME_NONE;
        unique case (cmd.kind)
            CMD_SET:
            begin
                busy_next     = 1'b0;
                freq_next     = cmd.new_freq;
                res_next.tune = 1'b1;
            end
            CMD_STEP_UP:
            begin
                busy_next     = 1'b0;
                freq_next     = up_freq;
                res_next.tune = 1'b1;
            end
            CMD_STEP_DOWN:
            begin
                busy_next     = 1'b0;
                freq_next     = down_freq;
                res_next.tune = 1'b1;
            end
            CMD_SEEK_UP, CMD_SEEK_DOWN:
            begin
                origin_next   = freq_reg;
                upward_next   = (cmd.kind == CMD_SEEK_UP);
                failed_next   = '0;
                busy_next     = 1'b1;
                freq_next     = (cmd.kind == CMD_SEEK_UP) ? up_freq : down_freq;
                res_next.tune = 1'b1;
            end
            CMD_MEASURE:
            begin
                if (busy_reg)
                begin
                    if (cmd.rssi_avg >= cfg.rssi_threshold)
                    begin
                        busy_next        = 1'b0;
                        res_next.outcome = OUTCOME_FOUND;
                    end
                    else
                    begin
                        failed_next = failed_inc;
                        if (failed_inc >= cfg.seek_step_limit)
                        begin
                            busy_next        = 1'b0;
                            freq_next        = origin_reg;
                            res_next.tune    = 1'b1;
                            res_next.outcome = OUTCOME_GAVE_UP;
                        end
                        else if (cmd.key)
                        begin
                            busy_next        = 1'b0;
                            res_next.outcome = OUTCOME_KEY;
                        end
                        else
                        begin
                            freq_next     = upward_reg ? up_freq : down_freq;
                            res_next.tune = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res_next.freq    = freq_next;
        res_next.running = busy_next;
    end

    // Tuner and seek state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= FREQ_RST;
            origin_reg    <= '0;
            upward_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            failed_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= issue;
            if (issue)
            begin
                freq_reg   <= freq_next;
                origin_reg <= origin_next;
                upward_reg <= upward_next;
                busy_reg   <= busy_next;
                failed_reg <= failed_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

/* rtl/core/fmts_display.sv */
// Display path: splits the frequency into decimal digits over three stages,
// maps them to segment bytes and queues the result. Depends on fmts_pkg, fmts_fifo.
`timescale 1ns / 1ps

module fmts_display
    import fmts_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  issue,
    output logic  space,
    input  res_t  res,
    input  logic  res_valid,
    input  logic  pop,
    output logic  empty,
    output disp_t disp
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // Stage A: thousands digit and remainder below 1000
    logic              a_valid_reg;
    res_t              a_res_reg;
    logic [1:0]        a_thou_reg, a_thou_next;
    logic [9:0]        a_rem_reg;
    logic [FREQ_W-1:0] a_rem_full;

    // Stage B: hundreds digit and remainder below 100
    logic              b_valid_reg;
    res_t              b_res_reg;
    logic [1:0]        b_thou_reg;
    logic [3:0]        b_hund_reg;
    logic [6:0]        b_rem_reg;
    logic [15:0]       hund_prod;
    logic [3:0]        hund;
    logic [9:0]        hund_back;

    // Stage C: tens and units, glyph lookup
    logic [13:0]       tens_prod;
    logic [3:0]        tens;
    logic [6:0]        tens_back;
    logic [6:0]        units_full;
    disp_t             disp_in;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop_fire;
    logic              q_empty;

    // Thousands by comparison, frequency is below 2048
    always_comb
    begin
        if (res.freq >= 11'd2000)
        begin
            a_thou_next = 2'd2;
            a_rem_full  = res.freq - 11'd2000;
        end
        else if (res.freq >= 11'd1000)
        begin
            a_thou_next = 2'd1;
            a_rem_full  = res.freq - 11'd1000;
        end
        else
        begin
            a_thou_next = 2'd0;
            a_rem_full  = res.freq;
        end
    end

    // Hundreds: x*41 >> 12 equals x/100 for x below 1000
    assign hund_prod = 16'(a_rem_reg) * 16'd41;
    assign hund      = hund_prod[15:12];
    assign hund_back = 10'(hund) * 10'd100;

    // Tens: x*103 >> 10 equals x/10 for x below 100
    assign tens_prod  = 14'(b_rem_reg) * 14'd103;
    assign tens       = tens_prod[13:10];
    assign tens_back  = 7'(tens) * 7'd10;
    assign units_full = b_rem_reg - tens_back;

    assign disp_in.res           = b_res_reg;
    assign disp_in.seg_thousands = (b_thou_reg == 2'd0) ? SEG_BLANK
                                                        : seg_glyph({2'b00, b_thou_reg});
    assign disp_in.seg_hundreds  = seg_glyph(b_hund_reg);
    assign disp_in.seg_tens      = seg_glyph(tens) & SEG_DP_MASK;
    assign disp_in.seg_units     = seg_glyph(units_full[3:0]);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= res_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            a_res_reg  <= res;
            a_thou_reg <= a_thou_next;
            a_rem_reg  <= a_rem_full[9:0];
        end
        if (a_valid_reg)
        begin
            b_res_reg  <= a_res_reg;
            b_thou_reg <= a_thou_reg;
            b_hund_reg <= hund;
            b_rem_reg  <= 7'(a_rem_reg - hund_back);
        end
    end

    // Credit count: transactions issued by the executor and not yet popped
    assign pop_fire = pop && !q_empty;
    assign space    = (cnt_reg < CNT_W'(OUT_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (issue && !pop_fire)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_fire && !issue)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    fmts_fifo #(
        .WIDTH ($bits(disp_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_valid_reg),
        .wr_data (disp_in),
        .rd_en   (pop),
        .rd_data (disp),
        .full    (),
        .empty   (q_empty)
    );

    assign empty = q_empty;

endmodule

/* rtl/core/fm_tuner_step_and_seek_control.sv */
// FM tuner step and seek controller, top level: configuration registers and
// the front, executor and display parts. Depends on fmts_pkg and all fmts_ modules.
`timescale 1ns / 1ps

// Every input transaction gives exactly one result transaction. The block takes
// one item per clock, back to back, while full is low. A result passes through
// the command queue, the executor register, two digit stages and the write into
// the result queue before it appears on the result ports. The rate is set by the
// executor, which updates the frequency and seek state once per command. The
// result queue holds OUT_DEPTH transactions; when it fills with unread results
// the command queue backs up and full rises after CMD_DEPTH more items.
// Configuration writes take effect on the next edge and should only be made
// while the block is idle.
module fm_tuner_step_and_seek_control
    import fmts_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [FREQ_W-1:0] cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [MODE_W-1:0] mode,
    input  logic [FREQ_W-1:0] new_frequency,
    input  logic [RSSI_W-1:0] rssi_first,
    input  logic [RSSI_W-1:0] rssi_second,
    input  logic              key_down,
    output logic              empty,
    input  logic              pop,
    output logic [FREQ_W-1:0] tune_frequency,
    output logic              tune_now,
    output logic              seek_running,
    output logic [1:0]        seek_outcome,
    output logic [SEG_W-1:0]  digit_thousands,
    output logic [SEG_W-1:0]  digit_hundreds,
    output logic [SEG_W-1:0]  digit_tens,
    output logic [SEG_W-1:0]  digit_units
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    logic  cmd_valid;
    logic  cmd_pop;
    logic  space;
    res_t  res;
    logic  res_valid;
    disp_t disp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rssi_threshold  <= THRESHOLD_RST;
            cfg_reg.seek_step_limit <= STEP_LIMIT_RST;
            cfg_reg.band_low        <= BAND_LOW_RST;
            cfg_reg.band_high       <= BAND_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_THRESHOLD:  cfg_reg.rssi_threshold  <= cfg_data[RSSI_W-1:0];
                CFG_IDX_STEP_LIMIT: cfg_reg.seek_step_limit <= cfg_data[LIMIT_W-1:0];
                CFG_IDX_BAND_LOW:   cfg_reg.band_low        <= cfg_data;
                CFG_IDX_BAND_HIGH:  cfg_reg.band_high       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fmts_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .new_frequency (new_frequency),
        .rssi_first    (rssi_first),
        .rssi_second   (rssi_second),
        .key_down      (key_down),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    fmts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .space     (space),
        .res       (res),
        .res_valid (res_valid)
    );

    fmts_display #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_display (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (cmd_pop),
        .space     (space),
        .res       (res),
        .res_valid (res_valid),
        .pop       (pop),
        .empty     (empty),
        .disp      (disp)
    );

    // Result fields
    assign tune_frequency  = disp.res.freq;
    assign tune_now        = disp.res.tune;
    assign seek_running    = disp.res.running;
    assign seek_outcome    = disp.res.outcome;
    assign digit_thousands = disp.seg_thousands;
    assign digit_hundreds  = disp.seg_hundreds;
    assign digit_tens      = disp.seg_tens;
    assign digit_units     = disp.seg_units;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for fm_tuner_step_and_seek_control: queue-style driver and
// result monitor, an in-bench tuner predictor and phased register settings.
// Depends on fmts_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
    import fmts_pkg::*;

    // Reserved mode codes, accepted by the block but without effect
    localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    // Active-low font, digit 0 in the lowest byte
    localparam logic [79:0] FONT = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

    localparam int PHASE_ITEMS = 280;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FREQ_W-1:0] new_freq;
        logic [RSSI_W-1:0] rssi_a;
        logic [RSSI_W-1:0] rssi_b;
        logic              key;
    } tuner_cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              tune;
        logic              running;
        logic [1:0]        outcome;
        logic [SEG_W-1:0]  seg_th;
        logic [SEG_W-1:0]  seg_hu;
        logic [SEG_W-1:0]  seg_te;
        logic [SEG_W-1:0]  seg_un;
        logic [63:0]       stamp;
    } tuner_readout_t;

    // DUT connections, all inputs known from time zero
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [FREQ_W-1:0] cfg_data = '0;
    logic              push = 1'b0;
    logic              full;
    logic [MODE_W-1:0] mode = '0;
    logic [FREQ_W-1:0] new_frequency = '0;
    logic [RSSI_W-1:0] rssi_first = '0;
    logic [RSSI_W-1:0] rssi_second = '0;
    logic              key_down = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [FREQ_W-1:0] tune_frequency;
    logic              tune_now;
    logic              seek_running;
    logic [1:0]        seek_outcome;
    logic [SEG_W-1:0]  digit_thousands;
    logic [SEG_W-1:0]  digit_hundreds;
    logic [SEG_W-1:0]  digit_tens;
    logic [SEG_W-1:0]  digit_units;

    // Predictor copy of the registers and tuner state
    logic [RSSI_W-1:0]  thr_cfg    = THRESHOLD_RST;
    logic [LIMIT_W-1:0] limit_cfg  = STEP_LIMIT_RST;
    logic [FREQ_W-1:0]  band_lo    = BAND_LOW_RST;
    logic [FREQ_W-1:0]  band_hi    = BAND_HIGH_RST;
    logic [FREQ_W-1:0]  tuned_freq = FREQ_RST;
    logic [FREQ_W-1:0]  seek_start = '0;
    logic               seek_dir_up = 1'b0;
    logic               seeking = 1'b0;
    logic [LIMIT_W-1:0] miss_count = '0;

    tuner_cmd_t     pending_cmds[$];
    tuner_readout_t predicted_readouts[$];
    tuner_cmd_t     cur_cmd;

    int error_count  = 0;
    int queued_count = 0;
    int sent_count   = 0;
    int results_seen = 0;
    int found_count  = 0;
    int key_count    = 0;
    int gaveup_count = 0;
    int hold_left    = 0;

    fm_tuner_step_and_seek_control uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .new_frequency   (new_frequency),
        .rssi_first      (rssi_first),
        .rssi_second     (rssi_second),
        .key_down        (key_down),
        .empty           (empty),
        .pop             (pop),
        .tune_frequency  (tune_frequency),
        .tune_now        (tune_now),
        .seek_running    (seek_running),
        .seek_outcome    (seek_outcome),
        .digit_thousands (digit_thousands),
        .digit_hundreds  (digit_hundreds),
        .digit_tens      (digit_tens),
        .digit_units     (digit_units)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Band stepping with wrap between the limits
    function automatic logic [FREQ_W-1:0] freq_up(input logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] n;
        n = f + 1'b1;
        return (n > band_hi) ? band_lo : n[FREQ_W-1:0];
    endfunction

    function automatic logic [FREQ_W-1:0] freq_down(input logic [FREQ_W-1:0] f);
        return (f <= band_lo) ? band_hi : f - 1'b1;
    endfunction

    function automatic logic [FREQ_W-1:0] seek_next(input logic [FREQ_W-1:0] f);
        return seek_dir_up ? freq_up(f) : freq_down(f);
    endfunction

    // Applies one command to the tuner state and returns the readout it gives
    function automatic tuner_readout_t tuner_predict(input tuner_cmd_t c);
        tuner_readout_t r;
        logic [RSSI_W:0] avg;
        int d;
        r = '0;
        case (c.mode)
            MODE_SET:
            begin
                seeking = 1'b0;
                tuned_freq = c.new_freq;
                r.tune = 1'b1;
            end
            MODE_STEP_UP:
            begin
                seeking = 1'b0;
                tuned_freq = freq_up(tuned_freq);
                r.tune = 1'b1;
            end
            MODE_STEP_DOWN:
            begin
                seeking = 1'b0;
                tuned_freq = freq_down(tuned_freq);
                r.tune = 1'b1;
            end
            MODE_SEEK_UP, MODE_SEEK_DOWN:
            begin
                seek_start = tuned_freq;
                seek_dir_up = (c.mode == MODE_SEEK_UP);
                miss_count = '0;
                seeking = 1'b1;
                tuned_freq = seek_next(tuned_freq);
                r.tune = 1'b1;
            end
            MODE_MEASURE:
            begin
                if (seeking)
                begin
                    avg = ({1'b0, c.rssi_a} + {1'b0, c.rssi_b}) >> 1;
                    if (avg >= thr_cfg)
                    begin
                        seeking = 1'b0;
                        r.outcome = OUTCOME_FOUND;
                        found_count++;
                    end
                    else
                    begin
                        miss_count = miss_count + 1'b1;
                        // step limit beats the key
                        if (miss_count >= limit_cfg)
                        begin
                            seeking = 1'b0;
                            tuned_freq = seek_start;
                            r.tune = 1'b1;
                            r.outcome = OUTCOME_GAVE_UP;
                            gaveup_count++;
                        end
                        else if (c.key)
                        begin
                            seeking = 1'b0;
                            r.outcome = OUTCOME_KEY;
                            key_count++;
                        end
                        else
                        begin
                            tuned_freq = seek_next(tuned_freq);
                            r.tune = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        d = tuned_freq;
        r.freq = tuned_freq;
        r.running = seeking;
        r.seg_th = (d >= 1000) ? FONT[((d / 1000) % 10) * 8 +: 8] : SEG_BLANK;
        r.seg_hu = FONT[((d / 100) % 10) * 8 +: 8];
        r.seg_te = FONT[((d / 10) % 10) * 8 +: 8] & SEG_DP_MASK;
        r.seg_un = FONT[(d % 10) * 8 +: 8];
        r.stamp = $time;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Driver: offers the pending commands, holds while full, idles now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predicted_readouts.push_back(tuner_predict(cur_cmd));
                sent_count++;
            end
            if (!push || !full)
            begin
                if (pending_cmds.size() != 0 &&
                    ((sent_count >= 600 && sent_count < 900) || $urandom_range(99) >= 6))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    push <= 1'b1;
                    mode <= cur_cmd.mode;
                    new_frequency <= cur_cmd.new_freq;
                    rssi_first <= cur_cmd.rssi_a;
                    rssi_second <= cur_cmd.rssi_b;
                    key_down <= cur_cmd.key;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        tuner_readout_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                // a prediction made at this very edge cannot be answered yet
                if (predicted_readouts.size() == 0 || predicted_readouts[0].stamp == $time)
                begin
                    $error("unexpected result transaction: tune_frequency %0d",
                           tune_frequency);
                    error_count++;
                end
                else
                begin
                    want = predicted_readouts.pop_front();
                    check_field("tune_frequency", want.freq, tune_frequency);
                    check_field("tune_now", want.tune, tune_now);
                    check_field("seek_running", want.running, seek_running);
                    check_field("seek_outcome", want.outcome, seek_outcome);
                    check_field("digit_thousands", want.seg_th, digit_thousands);
                    check_field("digit_hundreds", want.seg_hu, digit_hundreds);
                    check_field("digit_tens", want.seg_te, digit_tens);
                    check_field("digit_units", want.seg_un, digit_units);
                end
                results_seen++;
                // long hold-off so that the block backs up and raises full
                if (results_seen == 150 || results_seen == 1000)
                    hold_left = 80;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= (results_seen >= 600 && results_seen < 900) ||
                       $urandom_range(99) >= 6;
            end
        end
    end

    task automatic add_cmd(input logic [MODE_W-1:0] m, input logic [FREQ_W-1:0] nf,
                           input logic [RSSI_W-1:0] ra, input logic [RSSI_W-1:0] rb,
                           input logic k);
        tuner_cmd_t c;
        c.mode = m;
        c.new_freq = nf;
        c.rssi_a = ra;
        c.rssi_b = rb;
        c.key = k;
        pending_cmds.push_back(c);
        if (m <= MODE_MEASURE)
            queued_count++;
    endtask

    // Mostly a frequency inside the band, sometimes anywhere
    function automatic logic [FREQ_W-1:0] pick_freq();
        if (band_lo <= band_hi && $urandom_range(3) != 0)
            return FREQ_W'($urandom_range(band_hi, band_lo));
        return FREQ_W'($urandom_range(2047));
    endfunction

    // Readings mostly under the threshold so that seeks keep stepping
    task automatic add_measure();
        logic [RSSI_W-1:0] ra;
        logic [RSSI_W-1:0] rb;
        if (thr_cfg == 0 || $urandom_range(5) == 0)
        begin
            ra = RSSI_W'($urandom_range(255));
            rb = RSSI_W'($urandom_range(255));
        end
        else
        begin
            ra = RSSI_W'($urandom_range(thr_cfg - 1));
            rb = RSSI_W'($urandom_range(thr_cfg - 1));
        end
        add_cmd(MODE_MEASURE, FREQ_W'($urandom_range(2047)), ra, rb, $urandom_range(9) == 0);
    endtask

    task automatic add_seek_run();
        int n;
        if ($urandom_range(2) == 0)
            add_cmd(MODE_SET, pick_freq(), RSSI_W'($urandom_range(255)),
                    RSSI_W'($urandom_range(255)), 1'($urandom_range(1)));
        add_cmd($urandom_range(1) ? MODE_SEEK_UP : MODE_SEEK_DOWN,
                FREQ_W'($urandom_range(2047)), RSSI_W'($urandom_range(255)),
                RSSI_W'($urandom_range(255)), 1'($urandom_range(1)));
        n = $urandom_range((limit_cfg < 20) ? limit_cfg + 2 : 22, 1);
        repeat (n) add_measure();
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_IDX_THRESHOLD:  thr_cfg = val[RSSI_W-1:0];
            CFG_IDX_STEP_LIMIT: limit_cfg = val[LIMIT_W-1:0];
            CFG_IDX_BAND_LOW:   band_lo = val;
            CFG_IDX_BAND_HIGH:  band_hi = val;
            default: ;
        endcase
    endtask

    // Writes all four registers plus one stray index that must be ignored
    task automatic program_regs(input logic [RSSI_W-1:0] thr, input logic [LIMIT_W-1:0] lim,
                                input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi);
        write_reg(CFG_IDX_THRESHOLD, FREQ_W'(thr));
        write_reg(CFG_IDX_STEP_LIMIT, FREQ_W'(lim));
        write_reg(CFG_IDX_BAND_LOW, lo);
        write_reg(CFG_IDX_BAND_HIGH, hi);
        write_reg(IDX_W'(CFG_IDX_BAND_HIGH + $urandom_range(4, 1)),
                  FREQ_W'($urandom_range(2047)));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every prediction has been answered, then lets the pipeline settle
    task automatic drain();
        @(negedge clk);
        while (pending_cmds.size() != 0 || push || predicted_readouts.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Stimulus: directed checks at reset settings, then phased random traffic
    initial
    begin : stimulus
        int p;
        int made_start;
        int pick;
        logic [RSSI_W-1:0]  thr;
        logic [LIMIT_W-1:0] lim;
        logic [FREQ_W-1:0]  lo;
        logic [FREQ_W-1:0]  hi;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes and display blanking
        add_cmd(MODE_SET, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_SET, 11'd2047, 8'd255, 8'd255, 1'b1);
        add_cmd(MODE_SET, 11'd1999, 8'd0, 8'd0, 1'b0);
        // wrap at both band edges
        add_cmd(MODE_SET, 11'd1080, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_STEP_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_STEP_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_STEP_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
        // measurement with no seek running
        add_cmd(MODE_MEASURE, 11'd0, 8'd255, 8'd255, 1'b1);
        // station found at once
        add_cmd(MODE_SEEK_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_MEASURE, 11'd0, 8'd255, 8'd255, 1'b0);
        // one step, then key stop just under the threshold
        add_cmd(MODE_SEEK_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_MEASURE, 11'd0, 8'd10, 8'd20, 1'b0);
        add_cmd(MODE_MEASURE, 11'd0, 8'd22, 8'd23, 1'b1);
        // average exactly on the threshold
        add_cmd(MODE_SEEK_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_MEASURE, 11'd0, 8'd23, 8'd24, 1'b1);
        // reserved modes during a seek, then a step abandons it
        add_cmd(MODE_SEEK_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_UNUSED_A, 11'd2047, 8'd255, 8'd255, 1'b1);
        add_cmd(MODE_UNUSED_B, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_STEP_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_MEASURE, 11'd0, 8'd255, 8'd0, 1'b0);
        // set and a new seek both cut a running seek short
        add_cmd(MODE_SEEK_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_SET, 11'd1234, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_SEEK_UP, 11'd0, 8'd0, 8'd0, 1'b0);
        add_cmd(MODE_SEEK_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
        drain();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:       begin thr = 8'd255; lim = 10'd0;    lo = 11'd1100; hi = 11'd900;  end
                1:       begin thr = 8'd0;   lim = 10'd1023; lo = 11'd0;    hi = 11'd2047; end
                2:       begin thr = 8'd40;  lim = 10'd5;    lo = 11'd875;  hi = 11'd1080; end
                3:       begin thr = 8'd128; lim = 10'd1;    lo = 11'd0;    hi = 11'd0;    end
                4:       begin thr = 8'd60;  lim = 10'd12;   lo = 11'd760;  hi = 11'd1080; end
                default: begin thr = 8'd200; lim = 10'd3;    lo = 11'd2047; hi = 11'd2047; end
            endcase
            program_regs(thr, lim, lo, hi);

            if (p == 0)
            begin
                // inverted band stepping, zero step limit gives up at once
                add_cmd(MODE_SET, 11'd950, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_STEP_UP, 11'd0, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_STEP_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_STEP_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_SEEK_UP, 11'd0, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_MEASURE, 11'd0, 8'd254, 8'd255, 1'b1);
                add_cmd(MODE_SEEK_DOWN, 11'd0, 8'd0, 8'd0, 1'b0);
                add_cmd(MODE_MEASURE, 11'd0, 8'd255, 8'd255, 1'b0);
            end

            made_start = queued_count;
            while (queued_count - made_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                    add_seek_run();
                else if (pick < 85)
                    add_cmd(MODE_W'($urandom_range(MODE_STEP_DOWN, MODE_SET)), pick_freq(),
                            RSSI_W'($urandom_range(255)), RSSI_W'($urandom_range(255)),
                            1'($urandom_range(1)));
                else
                    add_cmd(MODE_W'($urandom_range(MODE_UNUSED_B)),
                            FREQ_W'($urandom_range(2047)), RSSI_W'($urandom_range(255)),
                            RSSI_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
            drain();
        end

        $display("Run covered %0d commands over 7 register settings, %0d results checked.",
                 sent_count, results_seen);
        $display("Seek endings seen: %0d found, %0d key stops, %0d gave up.",
                 found_count, key_count, gaveup_count);
        if (error_count == 0 && predicted_readouts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout: %0d results still outstanding", predicted_readouts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fmts_pkg.sv
rtl/core/fmts_fifo.sv
rtl/core/fmts_front.sv
rtl/core/fmts_back.sv
rtl/core/fmts_display.sv
rtl/core/fm_tuner_step_and_seek_control.sv
tb/tb_top.sv
